[src/lld_pkg.sv]
// Package for the lacing length-prefix deframer.
// Holds the length width, lacing constants and the state/result structs.
// No dependencies.
package lld_pkg;

  localparam int LEN_WIDTH = 24;

  localparam logic [7:0] LACE_CONT = 8'd255;

  typedef struct packed {
    logic                 in_payload;
    logic [LEN_WIDTH-1:0] length_sum;
    logic [LEN_WIDTH-1:0] bytes_left;
    logic                 overflow_seen;
  } lld_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       empty_frame;
    logic       frame_last;
    logic       truncated;
    logic       length_overflow;
  } lld_result_t;

endpackage

[src/lld_ifs.sv]
// Valid/ready channel interfaces for the deframer: raw byte input and
// deframed result output. Depends on nothing.
interface lld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface lld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       empty_frame;
  logic       frame_last;
  logic       truncated;
  logic       length_overflow;

  modport source (output valid, output data_byte, output empty_frame, output frame_last,
                  output truncated, output length_overflow, input ready);
  modport sink   (input valid, input data_byte, input empty_frame, input frame_last,
                  input truncated, input length_overflow, output ready);
endinterface

[src/lld_step.sv]
// Per-byte deframing logic: next state and optional result for one byte.
// Purely combinational. Depends on lld_pkg.
module lld_step (
  input  lld_pkg::lld_state_t  state,
  input  logic [7:0]           in_byte,
  input  logic                 stream_end,
  output lld_pkg::lld_state_t  state_next,
  output logic                 emit,
  output lld_pkg::lld_result_t result
);
  import lld_pkg::*;

  logic [LEN_WIDTH:0]   sum_ext;
  logic [LEN_WIDTH-1:0] sum_sat;
  logic                 ovf_now;
  logic [LEN_WIDTH-1:0] left_dec;

  // Saturating add of the lacing byte; the carry out is the overflow.
  assign sum_ext  = {1'b0, state.length_sum} + {{(LEN_WIDTH-7){1'b0}}, in_byte};
  assign sum_sat  = sum_ext[LEN_WIDTH] ? {LEN_WIDTH{1'b1}} : sum_ext[LEN_WIDTH-1:0];
  assign ovf_now  = state.overflow_seen | sum_ext[LEN_WIDTH];
  assign left_dec = (state.bytes_left != '0) ? state.bytes_left - LEN_WIDTH'(1)
                                             : state.bytes_left;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    result     = '0;

    if (!state.in_payload) begin
      state_next.length_sum    = sum_sat;
      state_next.overflow_seen = ovf_now;
      if (in_byte != LACE_CONT) begin
        if (sum_sat == '0) begin
          // empty frame marker
          emit                   = 1'b1;
          result.empty_frame     = 1'b1;
          result.frame_last      = 1'b1;
          result.length_overflow = ovf_now;
          state_next             = '0;
        end else if (stream_end) begin
          // header done but no payload will follow
          emit                   = 1'b1;
          result.empty_frame     = 1'b1;
          result.frame_last      = 1'b1;
          result.truncated       = 1'b1;
          result.length_overflow = ovf_now;
          state_next             = '0;
        end else begin
          state_next.in_payload = 1'b1;
          state_next.bytes_left = sum_sat;
          state_next.length_sum = '0;
        end
      end
    end else begin
      emit                   = 1'b1;
      result.data_byte       = in_byte;
      result.length_overflow = state.overflow_seen;
      state_next.bytes_left  = left_dec;
      if (left_dec == '0) begin
        result.frame_last = 1'b1;
        state_next        = '0;
      end else if (stream_end) begin
        result.frame_last = 1'b1;
        result.truncated  = 1'b1;
      end
    end

    if (stream_end) begin
      state_next = '0;
    end
  end

endmodule

[src/lacing_length_prefix_deframer_unit.sv]
// Lacing length-prefix deframer, top level.
// Latency: a result appears on egress the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single result register sets this, and
//   ingress stalls only while that register holds a result egress has not taken.
// Reset (rst, synchronous, active high): back to reading a lacing header,
//   length and overflow cleared, result register empty.
module lacing_length_prefix_deframer_unit (
  input  logic     clk,
  input  logic     rst,
  lld_in_if.sink   ingress,
  lld_out_if.source egress
);
  import lld_pkg::*;

  lld_state_t  state;
  lld_state_t  state_next;
  logic        emit;
  lld_result_t step_result;
  lld_result_t result;
  logic        result_valid;
  logic        accept;

  // Result register is empty or drains this cycle -> room for a new transaction.
  assign ingress.ready = !result_valid || egress.ready;
  assign accept        = ingress.valid && ingress.ready;

  lld_step u_step (
    .state      (state),
    .in_byte    (ingress.in_byte),
    .stream_end (ingress.stream_end),
    .state_next (state_next),
    .emit       (emit),
    .result     (step_result)
  );

  // Frame state advances on every accepted byte, header or payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register; a header (lacing) byte that emits no result leaves it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ingress.ready) begin
      result_valid <= accept && emit;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= step_result;
    end
  end

  assign egress.valid           = result_valid;
  assign egress.data_byte       = result.data_byte;
  assign egress.empty_frame     = result.empty_frame;
  assign egress.frame_last      = result.frame_last;
  assign egress.truncated       = result.truncated;
  assign egress.length_overflow = result.length_overflow;

endmodule

[src/lld_checker.sv]
// Port-level checks for the deframer top level, attached by bind.
// Depends on the top level's ingress and egress channels.
module lld_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic       empty_frame,
  input logic       frame_last,
  input logic       truncated,
  input logic       length_overflow
);

  // Result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A new result only follows an accepted byte.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without accepted byte");

  // Input never stalls while no result is pending.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("ingress stalled with empty result register");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(empty_frame)
      && $stable(frame_last) && $stable(truncated) && $stable(length_overflow))
    else $error("stalled result changed");

endmodule

bind lacing_length_prefix_deframer_unit lld_checker u_lld_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (ingress.valid),
  .in_ready        (ingress.ready),
  .out_valid       (egress.valid),
  .out_ready       (egress.ready),
  .data_byte       (egress.data_byte),
  .empty_frame     (egress.empty_frame),
  .frame_last      (egress.frame_last),
  .truncated       (egress.truncated),
  .length_overflow (egress.length_overflow)
);
